/* hw/rtl/ultrasonic_echo_proximity_alarm_macros.svh */
// assertion macros shared by the proximity alarm checkers
// needs clk_i and rst_ni in the scope where a macro is used
`ifndef ULTRASONIC_ECHO_PROXIMITY_ALARM_MACROS_SVH
`define ULTRASONIC_ECHO_PROXIMITY_ALARM_MACROS_SVH

// same-cycle implication, checked out of reset
`define UEPROX_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ueprox check failed");

// next-cycle implication, checked out of reset
`define UEPROX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ueprox check failed");

`endif

/* hw/rtl/ueprox_pkg.sv */
// shared types and constants for the ultrasonic proximity alarm
// no dependencies
`default_nettype none

package ueprox_pkg;

  localparam int unsigned CapW   = 16;
  localparam int unsigned WidthW = CapW + 1;
  localparam int unsigned CmpW   = CapW + 2;
  localparam int unsigned StepW  = 13;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CapW-1:0]  ModuloRst   = 16'd44999;
  localparam logic [CapW-1:0]  NearThrRst  = 16'd889;
  localparam logic [CapW-1:0]  MidThrRst   = 16'd1778;
  localparam logic [StepW-1:0] StepRst     = 13'd200;
  localparam logic [CapW-1:0]  TopRst      = 16'd6000;
  localparam logic [CapW-1:0]  RestartRst  = 16'd1000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODULO   = 3'd0,
    CFG_NEAR_THR = 3'd1,
    CFG_MID_THR  = 3'd2,
    CFG_STEP     = 3'd3,
    CFG_TOP      = 3'd4,
    CFG_RESTART  = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ZONE_NEAR = 2'd0,
    ZONE_MID  = 2'd1,
    ZONE_FAR  = 2'd2
  } zone_e;

  typedef struct packed {
    logic [CapW-1:0]  modulo;
    logic [CapW-1:0]  near_thr;
    logic [CapW-1:0]  mid_thr;
    logic [StepW-1:0] step;
    logic [CapW-1:0]  top;
    logic [CapW-1:0]  restart;
  } cfg_t;

  typedef struct packed {
    logic              second_edge;
    logic [WidthW-1:0] width;
    zone_e             zone;
  } meas_t;

endpackage

`default_nettype wire

/* hw/rtl/ueprox_meas.sv */
// edge pairing, pulse width with wrap correction and zone classification
// depends on ueprox_pkg
`default_nettype none

module ueprox_meas (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    adv_i,
  input  wire logic [ueprox_pkg::CapW-1:0] cap_i,
  input  wire ueprox_pkg::cfg_t        cfg_i,
  output ueprox_pkg::meas_t            meas_o
);

  logic                          parity_q, parity_d;
  logic [ueprox_pkg::CapW-1:0]   first_q, first_d;
  logic [ueprox_pkg::WidthW-1:0] width;
  logic [ueprox_pkg::CmpW-1:0]   width_x2;
  logic [ueprox_pkg::CmpW-1:0]   near_x3;
  logic [ueprox_pkg::CmpW-1:0]   mid_x3;
  ueprox_pkg::zone_e             zone;

  // width, adding a full counter period on wrap or equal captures
  always_comb begin
    if (cap_i > first_q) begin
      width = {1'b0, cap_i} - {1'b0, first_q};
    end else begin
      width = {1'b0, cap_i} + {1'b0, cfg_i.modulo} + ueprox_pkg::WidthW'(1)
              - {1'b0, first_q};
    end
  end

  // floor(2w/3) < t is the same as 2w < 3t
  assign width_x2 = {width, 1'b0};
  assign near_x3  = {2'b00, cfg_i.near_thr} + {1'b0, cfg_i.near_thr, 1'b0};
  assign mid_x3   = {2'b00, cfg_i.mid_thr} + {1'b0, cfg_i.mid_thr, 1'b0};

  always_comb begin
    if (width_x2 < near_x3) begin
      zone = ueprox_pkg::ZONE_NEAR;
    end else if (width_x2 < mid_x3) begin
      zone = ueprox_pkg::ZONE_MID;
    end else begin
      zone = ueprox_pkg::ZONE_FAR;
    end
  end

  // first edge of a pair is stored, the pair's other edge closes it
  always_comb begin
    parity_d = parity_q;
    first_d  = first_q;
    if (adv_i) begin
      parity_d = ~parity_q;
      if (!parity_q) begin
        first_d = cap_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parity_q <= 1'b0;
      first_q  <= '0;
    end else begin
      parity_q <= parity_d;
      first_q  <= first_d;
    end
  end

  assign meas_o.second_edge = parity_q;
  assign meas_o.width       = width;
  assign meas_o.zone        = zone;

endmodule

`default_nettype wire

/* hw/rtl/ueprox_buzz.sv */
// buzzer period index sweep, updated once per measurement
// depends on ueprox_pkg
`default_nettype none

module ueprox_buzz (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        step_en_i,
  input  wire ueprox_pkg::zone_e           zone_i,
  input  wire ueprox_pkg::cfg_t            cfg_i,
  output logic [ueprox_pkg::CapW-1:0]      period_o
);

  logic [ueprox_pkg::CapW-1:0] index_q, index_d;

  // near and mid sweep up and restart at the top, far parks at the top
  always_comb begin
    index_d = index_q;
    if (step_en_i) begin
      if (zone_i == ueprox_pkg::ZONE_FAR) begin
        index_d = cfg_i.top;
      end else if (index_q >= cfg_i.top) begin
        index_d = cfg_i.restart;
      end else begin
        index_d = index_q + ueprox_pkg::CapW'(cfg_i.step);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_q <= '0;
    end else begin
      index_q <= index_d;
    end
  end

  // period written this beat is the index before the update, or zero in the far zone
  assign period_o = (zone_i == ueprox_pkg::ZONE_FAR) ? '0 : index_q;

endmodule

`default_nettype wire

/* hw/rtl/ultrasonic_echo_proximity_alarm.sv */
// ultrasonic echo proximity alarm, top level
// throughput: one capture beat per cycle unless the output stalls, set by
// the single input stage and the single result register, which a beat
// passes in turn; the state update is one short pass
// reset: config registers return to their defaults, edge pairing and the
// buzzer index clear, both pipeline stages empty
`default_nettype none

module ultrasonic_echo_proximity_alarm (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // config write port
  input  wire logic                                cfg_we_i,
  input  wire logic [ueprox_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [ueprox_pkg::CapW-1:0]         cfg_wdata_i,
  // capture channel
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [ueprox_pkg::CapW-1:0]         capture_value_i,
  // result channel
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic                                     measurement_valid_o,
  output logic [ueprox_pkg::WidthW-1:0]            pulse_ticks_o,
  output logic [1:0]                               zone_o,
  output logic                                     red_led_on_o,
  output logic                                     blue_led_on_o,
  output logic                                     buzzer_enable_o,
  output logic [ueprox_pkg::CapW-1:0]              buzzer_period_o,
  output logic [ueprox_pkg::CapW-2:0]              buzzer_compare_o
);

  ueprox_pkg::cfg_t            cfg_q, cfg_d;
  logic                        in_valid_q, in_valid_d;
  logic [ueprox_pkg::CapW-1:0] cap_q;
  logic                        out_valid_q, out_valid_d;
  logic                        in_accept, adv;
  ueprox_pkg::meas_t           meas;
  logic [ueprox_pkg::CapW-1:0] period;

  logic                          mvalid_q;
  logic [ueprox_pkg::WidthW-1:0] ticks_q;
  ueprox_pkg::zone_e             zone_q;
  logic                          red_q, blue_q, buzz_q;
  logic [ueprox_pkg::CapW-1:0]   period_q;

  // config register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ueprox_pkg::CFG_MODULO:   cfg_d.modulo   = cfg_wdata_i;
        ueprox_pkg::CFG_NEAR_THR: cfg_d.near_thr = cfg_wdata_i;
        ueprox_pkg::CFG_MID_THR:  cfg_d.mid_thr  = cfg_wdata_i;
        ueprox_pkg::CFG_STEP:     cfg_d.step     = cfg_wdata_i[ueprox_pkg::StepW-1:0];
        ueprox_pkg::CFG_TOP:      cfg_d.top      = cfg_wdata_i;
        ueprox_pkg::CFG_RESTART:  cfg_d.restart  = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.modulo   <= ueprox_pkg::ModuloRst;
      cfg_q.near_thr <= ueprox_pkg::NearThrRst;
      cfg_q.mid_thr  <= ueprox_pkg::MidThrRst;
      cfg_q.step     <= ueprox_pkg::StepRst;
      cfg_q.top      <= ueprox_pkg::TopRst;
      cfg_q.restart  <= ueprox_pkg::RestartRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // pipeline handshake: input stage advances whenever the result slot frees
  assign adv        = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & ~adv;
  assign in_accept  = in_valid_i & ~in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q & ~out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // input capture register
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cap_q <= capture_value_i;
    end
  end

  ueprox_meas u_meas (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .cap_i  (cap_q),
    .cfg_i  (cfg_q),
    .meas_o (meas)
  );

  ueprox_buzz u_buzz (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (adv & meas.second_edge),
    .zone_i    (meas.zone),
    .cfg_i     (cfg_q),
    .period_o  (period)
  );

  // result register, all fields zero on the first edge of a pair
  always_ff @(posedge clk_i) begin
    if (adv) begin
      mvalid_q <= meas.second_edge;
      if (meas.second_edge) begin
        ticks_q  <= meas.width;
        zone_q   <= meas.zone;
        red_q    <= (meas.zone == ueprox_pkg::ZONE_NEAR);
        blue_q   <= (meas.zone == ueprox_pkg::ZONE_MID);
        buzz_q   <= (meas.zone != ueprox_pkg::ZONE_FAR);
        period_q <= period;
      end else begin
        ticks_q  <= '0;
        zone_q   <= ueprox_pkg::ZONE_NEAR;
        red_q    <= 1'b0;
        blue_q   <= 1'b0;
        buzz_q   <= 1'b0;
        period_q <= '0;
      end
    end
  end

  assign out_valid_o         = out_valid_q;
  assign measurement_valid_o = mvalid_q;
  assign pulse_ticks_o       = ticks_q;
  assign zone_o              = zone_q;
  assign red_led_on_o        = red_q;
  assign blue_led_on_o       = blue_q;
  assign buzzer_enable_o     = buzz_q;
  assign buzzer_period_o     = period_q;
  assign buzzer_compare_o    = period_q[ueprox_pkg::CapW-1:1];

endmodule

`default_nettype wire

/* hw/rtl/ueprox_chk.sv */
// port-level checker for the proximity alarm, bound to the top level
// depends on ultrasonic_echo_proximity_alarm_macros.svh and ueprox_pkg
`default_nettype none
`include "ultrasonic_echo_proximity_alarm_macros.svh"

module ueprox_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        measurement_valid_o,
  input wire logic [16:0] pulse_ticks_o,
  input wire logic [1:0]  zone_o,
  input wire logic        red_led_on_o,
  input wire logic        blue_led_on_o,
  input wire logic        buzzer_enable_o,
  input wire logic [15:0] buzzer_period_o,
  input wire logic [14:0] buzzer_compare_o
);

  logic        zero_result;
  logic        leds_match;
  logic        period_match;
  logic [53:0] beat_bits;

  // field groups used by the checks below
  assign zero_result  = (pulse_ticks_o == '0) && (zone_o == ueprox_pkg::ZONE_NEAR)
                        && !buzzer_enable_o && (buzzer_period_o == '0);
  assign leds_match   = (red_led_on_o == (zone_o == ueprox_pkg::ZONE_NEAR))
                        && (blue_led_on_o == (zone_o == ueprox_pkg::ZONE_MID))
                        && (buzzer_enable_o == (zone_o != ueprox_pkg::ZONE_FAR));
  assign period_match = (buzzer_enable_o || (buzzer_period_o == '0))
                        && (buzzer_compare_o == buzzer_period_o[15:1]);
  assign beat_bits    = {measurement_valid_o, pulse_ticks_o, zone_o, red_led_on_o,
                         blue_led_on_o, buzzer_enable_o, buzzer_period_o, buzzer_compare_o};

  // first edge of a pair carries an all-zero result
  `UEPROX_ASSERT_NOW(a_first_edge_zero, out_valid_o && !measurement_valid_o, zero_result)

  // indicators follow the zone
  `UEPROX_ASSERT_NOW(a_leds_match_zone, out_valid_o && measurement_valid_o, leds_match)

  // no period written while the buzzer is off, compare is half the period
  `UEPROX_ASSERT_NOW(a_period_consistent, out_valid_o, period_match)

  // a stalled result beat holds
  `UEPROX_ASSERT_NEXT(a_stall_holds, out_valid_o && out_stall_i, out_valid_o && $stable(beat_bits))

endmodule

bind ultrasonic_echo_proximity_alarm ueprox_chk u_ueprox_chk (.*);

`default_nettype wire
